// ----- rtl/tstt_pkg.sv -----
package tstt_pkg;

    // Operation codes carried in the input tuser field
    localparam logic [1:0] OP_ADV_SAMPLES = 2'd0;
    localparam logic [1:0] OP_ADV_TICKS   = 2'd1;
    localparam logic [1:0] OP_CLEAR       = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [1:0] REG_TEMPO_BPM   = 2'd1;
    localparam logic [1:0] REG_TPQN        = 2'd2;

    // Field and register widths
    localparam int POS_W   = 32;
    localparam int RATE_W  = 19;
    localparam int BPM_W   = 16;
    localparam int TPQN_W  = 15;
    localparam int CFG_W   = 19;
    localparam int RATE60_W = 25;
    localparam int SCALE_W = 31;
    localparam int PROD_W  = POS_W + SCALE_W;

    // The divider retires one quotient bit per cycle over the whole product
    localparam int DIV_STEPS = PROD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Register values after reset
    localparam logic [RATE_W-1:0] RESET_RATE = RATE_W'(44100);
    localparam logic [BPM_W-1:0]  RESET_BPM  = BPM_W'(120);
    localparam logic [TPQN_W-1:0] RESET_TPQN = TPQN_W'(480);

endpackage

// ----- rtl/tstt_mul.sv -----
module tstt_mul
(
    input  logic                            clk,
    input  logic [tstt_pkg::POS_W-1:0]      a,
    input  logic [tstt_pkg::SCALE_W-1:0]    b,
    output logic [tstt_pkg::PROD_W-1:0]     product
);

    logic [tstt_pkg::PROD_W-1:0] product_reg;

    // Shared unsigned multiplier with a registered product
    always_ff @(posedge clk)
    begin
        product_reg <= tstt_pkg::PROD_W'(a) * tstt_pkg::PROD_W'(b);
    end

    assign product = product_reg;

endmodule

// ----- rtl/tstt_div.sv -----
module tstt_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tstt_pkg::PROD_W-1:0]     dividend,
    input  logic [tstt_pkg::SCALE_W-1:0]    divisor,
    output logic                            done,
    output logic [tstt_pkg::POS_W-1:0]      quotient
);

    logic                               busy_reg;
    logic                               busy_next;
    logic                               done_reg;
    logic                               done_next;
    logic [tstt_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [tstt_pkg::DIV_CNT_W-1:0]     cnt_next;
    logic [tstt_pkg::SCALE_W-1:0]       rem_reg;
    logic [tstt_pkg::SCALE_W-1:0]       rem_next;
    logic [tstt_pkg::PROD_W-1:0]        dq_reg;
    logic [tstt_pkg::PROD_W-1:0]        dq_next;
    logic [tstt_pkg::SCALE_W-1:0]       div_hold_reg;
    logic [tstt_pkg::SCALE_W:0]         shifted;
    logic [tstt_pkg::SCALE_W:0]         diff;
    logic                               ge;

    // One restoring step: bring down the next dividend bit and trial-subtract
    assign shifted = {rem_reg, dq_reg[tstt_pkg::PROD_W-1]};
    assign diff    = shifted - {1'b0, div_hold_reg};
    assign ge      = (shifted >= {1'b0, div_hold_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = tstt_pkg::DIV_CNT_W'(tstt_pkg::DIV_STEPS - 1);
            rem_next  = '0;
            dq_next   = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[tstt_pkg::SCALE_W-1:0] : shifted[tstt_pkg::SCALE_W-1:0];
            dq_next  = {dq_reg[tstt_pkg::PROD_W-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        if (start)
        begin
            div_hold_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg[tstt_pkg::POS_W-1:0];

endmodule

// ----- rtl/tick_sample_timestamp_tracker.sv -----
// Tick and sample timestamp tracker.
//
// The slave stream carries one transaction per position update: tuser holds
// the operation (advance samples, advance ticks, clear) and tdata the signed
// 32-bit offset. After an advance the other position is recomputed by a
// scaling of the new position: one shared 32x31 multiplier forms the
// product and a bit-serial restoring divider retires one quotient bit per
// cycle over the 63-bit product. The master stream returns one transaction
// per input with both positions.
// An advance passes through the multiplier states ST_MUL_K, ST_MUL_P and
// ST_MUL_W, the divider steps and the load of the quotient; a clear or an
// unused code goes to the result state in the next cycle.
// One item is in flight at a time; s_tready is high only while idle, so
// no new item is taken while the multiplier and divider are working.
// A stalled result stays on m_tdata until m_tready is high, and no new input is
// taken until it has gone. Reset clears both positions and loads 44100 samples/s,
// 120 bpm and 480 ticks per quarter. Configuration writes take effect on the next
// update only if the user makes them while idle; the block does not enforce this.
module tick_sample_timestamp_tracker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] offset
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] sample_position, [63:32] tick_position
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [18:0] cfg_data
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MUL_K,
        ST_MUL_P,
        ST_MUL_W,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    logic [tstt_pkg::POS_W-1:0]         sample_reg;
    logic [tstt_pkg::POS_W-1:0]         sample_next;
    logic [tstt_pkg::POS_W-1:0]         tick_reg;
    logic [tstt_pkg::POS_W-1:0]         tick_next;
    logic [1:0]                         op_reg;
    logic [tstt_pkg::RATE_W-1:0]        rate_reg;
    logic [tstt_pkg::BPM_W-1:0]         bpm_reg;
    logic [tstt_pkg::TPQN_W-1:0]        tpqn_reg;

    logic [tstt_pkg::POS_W-1:0]         mag_reg;
    logic [tstt_pkg::POS_W-1:0]         mag_next;
    logic                               neg_reg;
    logic                               neg_next;
    logic [tstt_pkg::SCALE_W-1:0]       den_reg;
    logic [tstt_pkg::SCALE_W-1:0]       den_next;

    logic [tstt_pkg::POS_W-1:0]         pos_new;
    logic [tstt_pkg::RATE60_W-1:0]      rate60;
    logic [tstt_pkg::POS_W-1:0]         mul_a;
    logic [tstt_pkg::SCALE_W-1:0]       mul_b;
    logic [tstt_pkg::PROD_W-1:0]        mul_product;
    logic                               div_start;
    logic                               div_done;
    logic [tstt_pkg::POS_W-1:0]         div_quot;
    logic [tstt_pkg::POS_W-1:0]         scaled;
    logic                               in_fire;

    assign in_fire = s_tvalid && s_tready;

    // Samples per minute: rate * 60 as (rate << 6) - (rate << 2)
    assign rate60 = {rate_reg, 6'd0} - {4'd0, rate_reg, 2'd0};

    // Signed result of the division
    assign scaled = neg_reg ? (~div_quot + 1'b1) : div_quot;

    tstt_mul u_mul
    (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_product)
    );

    tstt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_product),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        sample_next = sample_reg;
        tick_next   = tick_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        den_next    = den_reg;
        div_start   = 1'b0;
        pos_new     = '0;
        mul_a       = {{(tstt_pkg::POS_W - tstt_pkg::TPQN_W){1'b0}}, tpqn_reg};
        mul_b       = {{(tstt_pkg::SCALE_W - tstt_pkg::BPM_W){1'b0}}, bpm_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (s_tuser)
                        tstt_pkg::OP_ADV_SAMPLES:
                        begin
                            pos_new     = sample_reg + s_tdata;
                            sample_next = pos_new;
                            state_next  = ST_MUL_K;
                        end
                        tstt_pkg::OP_ADV_TICKS:
                        begin
                            pos_new    = tick_reg + s_tdata;
                            tick_next  = pos_new;
                            state_next = ST_MUL_K;
                        end
                        tstt_pkg::OP_CLEAR:
                        begin
                            sample_next = '0;
                            tick_next   = '0;
                            state_next  = ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                    neg_next = pos_new[tstt_pkg::POS_W-1];
                    mag_next = pos_new[tstt_pkg::POS_W-1] ? (~pos_new + 1'b1) : pos_new;
                end
            end
            ST_MUL_K:
            begin
                // Multiplier forms ticks_per_quarter * tempo_bpm
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                // Multiplier forms |position| * numerator
                mul_a = mag_reg;
                if (op_reg == tstt_pkg::OP_ADV_SAMPLES)
                begin
                    mul_b    = mul_product[tstt_pkg::SCALE_W-1:0];
                    den_next = {{(tstt_pkg::SCALE_W - tstt_pkg::RATE60_W){1'b0}}, rate60};
                end
                else
                begin
                    mul_b    = {{(tstt_pkg::SCALE_W - tstt_pkg::RATE60_W){1'b0}}, rate60};
                    den_next = mul_product[tstt_pkg::SCALE_W-1:0];
                end
                state_next = ST_MUL_W;
            end
            ST_MUL_W:
            begin
                // A zero divisor gives a zero position without dividing
                if (den_reg == '0)
                begin
                    if (op_reg == tstt_pkg::OP_ADV_SAMPLES)
                    begin
                        tick_next = '0;
                    end
                    else
                    begin
                        sample_next = '0;
                    end
                    state_next = ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (op_reg == tstt_pkg::OP_ADV_SAMPLES)
                    begin
                        tick_next = scaled;
                    end
                    else
                    begin
                        sample_next = scaled;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, positions and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sample_reg <= '0;
            tick_reg   <= '0;
            op_reg     <= tstt_pkg::OP_CLEAR;
            rate_reg   <= tstt_pkg::RESET_RATE;
            bpm_reg    <= tstt_pkg::RESET_BPM;
            tpqn_reg   <= tstt_pkg::RESET_TPQN;
        end
        else
        begin
            state_reg  <= state_next;
            sample_reg <= sample_next;
            tick_reg   <= tick_next;
            if (in_fire)
            begin
                op_reg <= s_tuser;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    tstt_pkg::REG_SAMPLE_RATE: rate_reg <= cfg_data[tstt_pkg::RATE_W-1:0];
                    tstt_pkg::REG_TEMPO_BPM:   bpm_reg  <= cfg_data[tstt_pkg::BPM_W-1:0];
                    tstt_pkg::REG_TPQN:        tpqn_reg <= cfg_data[tstt_pkg::TPQN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Operand registers for the multiply and divide
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        den_reg <= den_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {tick_reg, sample_reg};

endmodule

// ----- rtl/tstt_checker.sv -----
module tstt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // Only one update is in flight: input and output are never open together
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // Accepting an update takes s_tready low
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready after a transaction");

    // A clear reports both positions as zero on the next cycle
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == tstt_pkg::OP_CLEAR)
            |=> (m_tvalid && m_tdata == 64'd0))
        else $error("clear did not report zero positions");

    // Once the result is taken the block is ready again
    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
        else $error("block not idle after result transaction");

    // A stalled result holds its positions
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind tick_sample_timestamp_tracker tstt_checker u_tstt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
